FILE: hw/rtl/rgbpc_pkg.sv
// Shared types and constants for the RGBA pixel combiner.
package rgbpc_pkg;

  localparam int NUM_CH    = 4;
  localparam int RGB_COUNT = 3;
  localparam int CH_W      = 8;
  localparam int OP_W      = 4;

  localparam int CH_R = 0;
  localparam int CH_G = 1;
  localparam int CH_B = 2;
  localparam int CH_A = 3;

  localparam logic [CH_W-1:0]   CH_MAX    = 8'd255;
  localparam logic [2*CH_W-1:0] MUL_ROUND = 16'd127;
  // floor(x/3) == (x * 683) >> 11 for every x below 2048
  localparam logic [9:0]        RECIP3    = 10'd683;
  localparam int                RECIP3_SH = 11;

  // Restoring divide: one quotient bit per step, two steps per stage
  localparam int DIV_STEPS     = 8;
  localparam int STEPS_PER_STG = 2;
  localparam int DIV_STAGES    = DIV_STEPS / STEPS_PER_STG;

  typedef enum logic [OP_W-1:0] {
    OP_MUL   = 4'd0,
    OP_ADD   = 4'd1,
    OP_PATCH = 4'd2,
    OP_INVA  = 4'd3,
    OP_INVC  = 4'd4,
    OP_INTEN = 4'd5,
    OP_MKA   = 4'd6,
    OP_EXTA  = 4'd7,
    OP_DIVA  = 4'd8,
    OP_PASS  = 4'd9
  } op_t;

  localparam logic [OP_W-1:0] OP_LAST_CODE = OP_PASS;

  typedef logic [NUM_CH-1:0][CH_W-1:0] pixel_t;

  typedef struct packed {
    op_t    op;
    pixel_t first;
    pixel_t second;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: hw/rtl/rgbpc_chan_if.sv
// Channel interfaces of the RGBA pixel combiner: pixel pair in, pixel out, config write.
interface rgbpc_pix_in_if import rgbpc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] first_red;
  logic [CH_W-1:0] first_green;
  logic [CH_W-1:0] first_blue;
  logic [CH_W-1:0] first_alpha;
  logic [CH_W-1:0] second_red;
  logic [CH_W-1:0] second_green;
  logic [CH_W-1:0] second_blue;
  logic [CH_W-1:0] second_alpha;

  modport source (
    output valid, first_red, first_green, first_blue, first_alpha,
    output second_red, second_green, second_blue, second_alpha,
    input  ready
  );
  modport sink (
    input  valid, first_red, first_green, first_blue, first_alpha,
    input  second_red, second_green, second_blue, second_alpha,
    output ready
  );
endinterface

interface rgbpc_pix_out_if import rgbpc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] out_red;
  logic [CH_W-1:0] out_green;
  logic [CH_W-1:0] out_blue;
  logic [CH_W-1:0] out_alpha;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha,
    output ready
  );
endinterface

interface rgbpc_cfg_if import rgbpc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: hw/rtl/rgbpc_front.sv
// Front end: operation register, input accept and operation classification.
module rgbpc_front import rgbpc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  rgbpc_pix_in_if.sink  in_pix,
  rgbpc_cfg_if.sink     cfg_wr,
  input  q_stat_t       q_stat,
  output logic          push_valid,
  output entry_t        push_entry
);

  logic [OP_W-1:0] op_code_r;
  logic [OP_W-1:0] op_code_nxt;
  op_t             op_cls;

  assign cfg_wr.ready = 1'b1;

  always_comb begin
    op_code_nxt = op_code_r;
    if (cfg_wr.valid) begin
      op_code_nxt = cfg_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_code_r <= OP_PASS;
    end else begin
      op_code_r <= op_code_nxt;
    end
  end

  // Fold unused codes and divide by zero alpha into pass
  always_comb begin
    if (op_code_r <= OP_LAST_CODE) begin
      op_cls = op_t'(op_code_r);
    end else begin
      op_cls = OP_PASS;
    end
    if (op_cls == OP_DIVA && in_pix.first_alpha == '0) begin
      op_cls = OP_PASS;
    end
  end

  assign in_pix.ready = !q_stat.full;
  assign push_valid   = in_pix.valid;

  always_comb begin
    push_entry.op           = op_cls;
    push_entry.first[CH_R]  = in_pix.first_red;
    push_entry.first[CH_G]  = in_pix.first_green;
    push_entry.first[CH_B]  = in_pix.first_blue;
    push_entry.first[CH_A]  = in_pix.first_alpha;
    push_entry.second[CH_R] = in_pix.second_red;
    push_entry.second[CH_G] = in_pix.second_green;
    push_entry.second[CH_B] = in_pix.second_blue;
    push_entry.second[CH_A] = in_pix.second_alpha;
  end

endmodule

FILE: hw/rtl/rgbpc_queue.sv
// Short queue of classified words between front and back end.
module rgbpc_queue import rgbpc_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push_valid,
  input  entry_t  push_entry,
  input  logic    pop_ready,
  output entry_t  head_entry,
  output q_stat_t q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  entry_t           mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push_fire;
  logic             pop_fire;

  assign q_stat.full  = (count_r == FULL_CNT);
  assign q_stat.empty = (count_r == '0);
  assign push_fire    = push_valid && !q_stat.full;
  assign pop_fire     = pop_ready && !q_stat.empty;
  assign head_entry   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_fire) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_fire) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_fire && !pop_fire) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_fire && !push_fire) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("queue count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push_fire && !pop_fire) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not grow on push");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (q_stat.empty || q_stat.full) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");

endmodule

FILE: hw/rtl/rgbpc_back.sv
// Back end: pixel arithmetic pipeline with staged divider and output register.
module rgbpc_back import rgbpc_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  entry_t          head_entry,
  input  q_stat_t         q_stat,
  output logic            pop_ready,
  rgbpc_pix_out_if.source out_pix
);

  localparam int NSTG = DIV_STAGES + 1;

  typedef struct packed {
    op_t                                 op;
    pixel_t                              res;
    logic [NUM_CH-1:0][2*CH_W-1:0]       prod;
    logic [RGB_COUNT-1:0][CH_W-1:0]      rem;
    logic [RGB_COUNT-1:0][CH_W-1:0]      nlo;
    logic [RGB_COUNT-1:0][CH_W-1:0]      quo;
    logic [RGB_COUNT-1:0]                sat;
  } rec_t;

  rec_t   pipe_r   [NSTG];
  rec_t   pipe_nxt [NSTG];
  logic   vld_r    [NSTG];
  pixel_t out_r, out_nxt;
  logic   out_vld_r;
  logic   en;

  function automatic rec_t rec_init(entry_t e);
    rec_t                r;
    logic [2*CH_W-1:0]   n;
    logic [CH_W:0]       s;
    logic [CH_W+1:0]     sum3;
    logic [19:0]         q3;
    r.op   = e.op;
    r.res  = e.first;
    r.sat  = '0;
    r.quo  = '0;
    for (int i = 0; i < NUM_CH; i++) begin
      r.prod[i] = e.first[i] * e.second[i];
    end
    for (int i = 0; i < RGB_COUNT; i++) begin
      n        = {e.first[i], {CH_W{1'b0}}} - {{CH_W{1'b0}}, e.first[i]};
      r.rem[i] = n[2*CH_W-1:CH_W];
      r.nlo[i] = n[CH_W-1:0];
      r.sat[i] = (e.first[i] >= e.first[CH_A]);
    end
    sum3 = {2'b00, e.first[CH_R]} + {2'b00, e.first[CH_G]} + {2'b00, e.first[CH_B]};
    q3   = sum3 * RECIP3;
    case (e.op)
      OP_ADD: begin
        for (int i = 0; i < NUM_CH; i++) begin
          s = {1'b0, e.first[i]} + {1'b0, e.second[i]};
          r.res[i] = s[CH_W] ? CH_MAX : s[CH_W-1:0];
        end
      end
      OP_PATCH: r.res[CH_A] = e.second[CH_A];
      OP_INVA:  r.res[CH_A] = CH_MAX - e.first[CH_A];
      OP_INVC: begin
        for (int i = 0; i < RGB_COUNT; i++) begin
          r.res[i] = CH_MAX - e.first[i];
        end
      end
      OP_INTEN: begin
        for (int i = 0; i < NUM_CH; i++) begin
          r.res[i] = e.first[CH_R];
        end
      end
      OP_MKA: begin
        for (int i = 0; i < RGB_COUNT; i++) begin
          r.res[i] = CH_MAX;
        end
        r.res[CH_A] = q3[RECIP3_SH +: CH_W];
      end
      OP_EXTA: begin
        for (int i = 0; i < RGB_COUNT; i++) begin
          r.res[i] = e.first[CH_A];
        end
        r.res[CH_A] = CH_MAX;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Two restoring steps; divisor is the first pixel's alpha kept in res
  function automatic rec_t div_step(rec_t r_in);
    rec_t          r;
    logic [CH_W:0] t;
    r = r_in;
    for (int i = 0; i < RGB_COUNT; i++) begin
      for (int k = 0; k < STEPS_PER_STG; k++) begin
        t = {r.rem[i], r.nlo[i][CH_W-1]};
        r.nlo[i] = {r.nlo[i][CH_W-2:0], 1'b0};
        if (t >= {1'b0, r.res[CH_A]}) begin
          t        = t - {1'b0, r.res[CH_A]};
          r.quo[i] = {r.quo[i][CH_W-2:0], 1'b1};
        end else begin
          r.quo[i] = {r.quo[i][CH_W-2:0], 1'b0};
        end
        r.rem[i] = t[CH_W-1:0];
      end
    end
    return r;
  endfunction

  function automatic pixel_t finish(rec_t r);
    pixel_t            p;
    logic [2*CH_W-1:0] x;
    logic [2*CH_W-1:0] y;
    p = r.res;
    case (r.op)
      OP_MUL: begin
        // x / 255 == (x + 1 + (x >> 8)) >> 8 over the product range
        for (int i = 0; i < NUM_CH; i++) begin
          x    = r.prod[i] + MUL_ROUND;
          y    = x + 16'd1 + {{CH_W{1'b0}}, x[2*CH_W-1:CH_W]};
          p[i] = y[2*CH_W-1:CH_W];
        end
      end
      OP_DIVA: begin
        for (int i = 0; i < RGB_COUNT; i++) begin
          p[i] = r.sat[i] ? CH_MAX : r.quo[i];
        end
      end
      default: ;
    endcase
    return p;
  endfunction

  // Whole back end advances together; hold on output stall
  assign en        = !out_vld_r || out_pix.ready;
  assign pop_ready = en;

  always_comb begin
    pipe_nxt[0] = rec_init(head_entry);
    for (int k = 1; k < NSTG; k++) begin
      pipe_nxt[k] = div_step(pipe_r[k-1]);
    end
    out_nxt = finish(pipe_r[NSTG-1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NSTG; k++) begin
        vld_r[k] <= 1'b0;
      end
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= !q_stat.empty;
      for (int k = 1; k < NSTG; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
      out_vld_r <= vld_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NSTG; k++) begin
        pipe_r[k] <= pipe_nxt[k];
      end
      out_r <= out_nxt;
    end
  end

  assign out_pix.valid     = out_vld_r;
  assign out_pix.out_red   = out_r[CH_R];
  assign out_pix.out_green = out_r[CH_G];
  assign out_pix.out_blue  = out_r[CH_B];
  assign out_pix.out_alpha = out_r[CH_A];

endmodule

FILE: hw/rtl/rgba_pixel_combiner_core.sv
// Top level of the RGBA pixel combiner.
// Takes one pair of RGBA8 pixels per word and returns one RGBA8 pixel per word, in order.
// The operation register (reset: pass) selects multiply, saturating add, patch alpha,
// invert alpha, invert color, intensity, make alpha, extract alpha, un-premultiply or
// pass; codes above 9 act as pass. Write it only while no word is in flight.
// Sustained rate is one word per clock while the output does not stall. From input accept
// to output valid a word passes the front queue, the multiply stage, the four
// un-premultiply divider stages (two quotient bits per stage) and the output register.
// The queue absorbs up to QUEUE_DEPTH words while the output stalls; then input waits.
module rgba_pixel_combiner_core import rgbpc_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  rgbpc_pix_in_if.sink    in_pix,
  rgbpc_pix_out_if.source out_pix,
  rgbpc_cfg_if.sink       cfg_wr
);

  logic    push_valid;
  entry_t  push_entry;
  entry_t  head_entry;
  logic    pop_ready;
  q_stat_t q_stat;

  rgbpc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_pix     (in_pix),
    .cfg_wr     (cfg_wr),
    .q_stat     (q_stat),
    .push_valid (push_valid),
    .push_entry (push_entry)
  );

  rgbpc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .pop_ready  (pop_ready),
    .head_entry (head_entry),
    .q_stat     (q_stat)
  );

  rgbpc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_entry (head_entry),
    .q_stat     (q_stat),
    .pop_ready  (pop_ready),
    .out_pix    (out_pix)
  );

endmodule

FILE: test/tb_rgba_pixel_combiner_core.sv
// Self-checking testbench for the RGBA pixel combiner core: random pixel pairs under every operation.
`timescale 1ns / 1ps

module tb_rgba_pixel_combiner_core;
  import rgbpc_pkg::*;

  localparam int PIPE_LAT    = 7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 60;
  localparam logic [OP_W-1:0] OP_SPARE_LO = OP_LAST_CODE + 1'b1;
  localparam logic [OP_W-1:0] OP_SPARE_HI = '1;

  typedef enum {JOB_PIX, JOB_CFG, JOB_DRAIN} job_kind_t;

  typedef struct {
    job_kind_t       kind;
    logic [OP_W-1:0] op;
    pixel_t          first;
    pixel_t          second;
    int unsigned     gap;
  } job_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rgbpc_pix_in_if  pin ();
  rgbpc_pix_out_if pout ();
  rgbpc_cfg_if     cfg_ch ();

  rgba_pixel_combiner_core DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (pin),
    .out_pix (pout),
    .cfg_wr  (cfg_ch)
  );

  job_t            feed_q[$];
  pixel_t          due_pix[$];
  logic [OP_W-1:0] cur_op;
  int unsigned     tx_gap;
  int unsigned     wait_cnt;
  int unsigned     quiet_cnt;
  int unsigned     rx_hold;
  bit              rx_calm;
  int unsigned     errors = 0;
  int unsigned     cycles = 0;
  string           ch_tag[NUM_CH] = '{"red", "green", "blue", "alpha"};

  always #5 clk = ~clk;

  // Expected result pixel for one pixel pair under the given operation code
  function automatic pixel_t combine_pixel(logic [OP_W-1:0] op, pixel_t p, pixel_t q);
    pixel_t      r;
    int unsigned t;
    r = p;
    case (op)
      OP_MUL: begin
        for (int c = 0; c < NUM_CH; c++) begin
          t = (int'(p[c]) * int'(q[c]) + int'(MUL_ROUND)) / int'(CH_MAX);
          r[c] = t[CH_W-1:0];
        end
      end
      OP_ADD: begin
        for (int c = 0; c < NUM_CH; c++) begin
          t = int'(p[c]) + int'(q[c]);
          r[c] = (t > CH_MAX) ? CH_MAX : t[CH_W-1:0];
        end
      end
      OP_PATCH: r[CH_A] = q[CH_A];
      OP_INVA:  r[CH_A] = CH_MAX - p[CH_A];
      OP_INVC: begin
        for (int c = 0; c < RGB_COUNT; c++) r[c] = CH_MAX - p[c];
      end
      OP_INTEN: begin
        for (int c = 0; c < NUM_CH; c++) r[c] = p[CH_R];
      end
      OP_MKA: begin
        t = (int'(p[CH_R]) + int'(p[CH_G]) + int'(p[CH_B])) / RGB_COUNT;
        r[CH_A] = t[CH_W-1:0];
        for (int c = 0; c < RGB_COUNT; c++) r[c] = CH_MAX;
      end
      OP_EXTA: begin
        for (int c = 0; c < RGB_COUNT; c++) r[c] = p[CH_A];
        r[CH_A] = CH_MAX;
      end
      OP_DIVA: begin
        // zero alpha leaves the pixel as it is
        if (p[CH_A] != 0) begin
          for (int c = 0; c < RGB_COUNT; c++) begin
            t = (int'(p[c]) * int'(CH_MAX)) / int'(p[CH_A]);
            r[c] = (t > CH_MAX) ? CH_MAX : t[CH_W-1:0];
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic pixel_t mk_pix(int r, int g, int b, int a);
    pixel_t px;
    px[CH_R] = r[CH_W-1:0];
    px[CH_G] = g[CH_W-1:0];
    px[CH_B] = b[CH_W-1:0];
    px[CH_A] = a[CH_W-1:0];
    return px;
  endfunction

  // Lean on the edges of the range: they hit saturation and the zero-alpha case
  function automatic logic [CH_W-1:0] rand_chan();
    logic [CH_W-1:0] v;
    case ($urandom_range(0, 7))
      0:       v = 8'd0;
      1:       v = 8'd1;
      2:       v = 8'd254;
      3:       v = 8'd255;
      default: v = CH_W'($urandom_range(0, 255));
    endcase
    return v;
  endfunction

  function automatic pixel_t rand_pix();
    pixel_t px;
    for (int c = 0; c < NUM_CH; c++) px[c] = rand_chan();
    return px;
  endfunction

  task automatic queue_pix(pixel_t f, pixel_t s, int unsigned gap);
    job_t j;
    j.kind = JOB_PIX;
    j.op = OP_PASS;
    j.first = f;
    j.second = s;
    j.gap = gap;
    feed_q.push_back(j);
  endtask

  task automatic queue_cfg(logic [OP_W-1:0] op);
    job_t j;
    j.kind = JOB_CFG;
    j.op = op;
    j.first = '0;
    j.second = '0;
    j.gap = 0;
    feed_q.push_back(j);
  endtask

  task automatic queue_drain();
    job_t j;
    j.kind = JOB_DRAIN;
    j.op = OP_PASS;
    j.first = '0;
    j.second = '0;
    j.gap = 0;
    feed_q.push_back(j);
  endtask

  initial begin
    pin.valid = 1'b0;
    pin.first_red = '0;
    pin.first_green = '0;
    pin.first_blue = '0;
    pin.first_alpha = '0;
    pin.second_red = '0;
    pin.second_green = '0;
    pin.second_blue = '0;
    pin.second_alpha = '0;
    pout.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Sender: present words from the feed queue, hold until accepted
  always @(posedge clk) begin
    job_t j;
    logic nv_in;
    logic nv_cfg;
    if (!rst_n) begin
      pin.valid <= 1'b0;
      cfg_ch.valid <= 1'b0;
      cur_op = OP_PASS;
      tx_gap = 0;
      wait_cnt = 0;
      quiet_cnt = 0;
    end else begin
      nv_in = pin.valid;
      nv_cfg = cfg_ch.valid;
      if (pin.valid && pin.ready) begin
        due_pix.push_back(combine_pixel(cur_op,
          {pin.first_alpha, pin.first_blue, pin.first_green, pin.first_red},
          {pin.second_alpha, pin.second_blue, pin.second_green, pin.second_red}));
        nv_in = 1'b0;
        wait_cnt = tx_gap;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        cur_op = cfg_ch.data;
        nv_cfg = 1'b0;
      end
      if (due_pix.size() == 0 && !pin.valid) quiet_cnt++;
      else quiet_cnt = 0;
      if (!nv_in && !nv_cfg) begin
        if (wait_cnt > 0) begin
          wait_cnt--;
        end else if (feed_q.size() > 0) begin
          case (feed_q[0].kind)
            JOB_PIX: begin
              j = feed_q.pop_front();
              nv_in = 1'b1;
              tx_gap = j.gap;
              pin.first_red <= j.first[CH_R];
              pin.first_green <= j.first[CH_G];
              pin.first_blue <= j.first[CH_B];
              pin.first_alpha <= j.first[CH_A];
              pin.second_red <= j.second[CH_R];
              pin.second_green <= j.second[CH_G];
              pin.second_blue <= j.second[CH_B];
              pin.second_alpha <= j.second[CH_A];
            end
            JOB_CFG: begin
              // write the register only once the pipe has gone quiet
              if (quiet_cnt > PIPE_LAT + 3) begin
                j = feed_q.pop_front();
                nv_cfg = 1'b1;
                cfg_ch.data <= j.op;
              end
            end
            JOB_DRAIN: begin
              if (due_pix.size() == 0) void'(feed_q.pop_front());
            end
            default: ;
          endcase
        end
      end
      pin.valid <= nv_in;
      cfg_ch.valid <= nv_cfg;
    end
  end

  // Receiver: check each result word against the oldest expected pixel
  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    if (!rst_n) begin
      pout.ready <= 1'b0;
      rx_hold = 0;
      rx_calm = 1'b0;
    end else begin
      if (pout.valid && pout.ready) begin
        got = {pout.out_alpha, pout.out_blue, pout.out_green, pout.out_red};
        if (due_pix.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected pixel, expected none actual %h", $time, got);
        end else begin
          want = due_pix.pop_front();
          for (int c = 0; c < NUM_CH; c++) begin
            if (got[c] !== want[c]) begin
              errors++;
              if (errors <= MAX_REPORTS)
                $display("%0t: %s expected %0d actual %0d", $time, ch_tag[c], want[c], got[c]);
            end
          end
        end
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
        rx_hold = rx_calm ? 0 : $urandom_range(0, 10);
      end
      if (rx_hold > 0) begin
        rx_hold--;
        pout.ready <= 1'b0;
      end else begin
        pout.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [OP_W-1:0] code;
    bit              calm;
    int              n;

    // reset value of the register is pass; the second pixel must not matter
    queue_pix(mk_pix(12, 34, 56, 78), mk_pix(255, 255, 255, 255), 0);

    queue_cfg(OP_MUL);
    queue_pix(mk_pix(0, 0, 0, 0), mk_pix(0, 0, 0, 0), $urandom_range(0, 10));
    queue_pix(mk_pix(255, 255, 255, 255), mk_pix(255, 255, 255, 255), 0);
    queue_pix(mk_pix(255, 128, 1, 170), mk_pix(1, 128, 255, 85), $urandom_range(0, 10));
    queue_drain();

    queue_cfg(OP_ADD);
    queue_pix(mk_pix(255, 255, 255, 255), mk_pix(255, 255, 255, 255), 0);
    queue_pix(mk_pix(0, 100, 200, 1), mk_pix(0, 155, 56, 254), $urandom_range(0, 10));

    queue_cfg(OP_PATCH);
    queue_pix(mk_pix(10, 20, 30, 40), mk_pix(1, 2, 3, 200), 0);
    queue_cfg(OP_INVA);
    queue_pix(mk_pix(0, 255, 7, 0), mk_pix(9, 9, 9, 9), 0);
    queue_cfg(OP_INVC);
    queue_pix(mk_pix(0, 255, 170, 85), mk_pix(1, 1, 1, 1), 0);
    queue_cfg(OP_INTEN);
    queue_pix(mk_pix(200, 1, 2, 3), mk_pix(4, 5, 6, 7), 0);

    queue_cfg(OP_MKA);
    queue_pix(mk_pix(255, 255, 255, 0), mk_pix(0, 0, 0, 0), 0);
    queue_pix(mk_pix(1, 1, 0, 9), mk_pix(0, 0, 0, 0), 0);

    queue_cfg(OP_EXTA);
    queue_pix(mk_pix(1, 2, 3, 77), mk_pix(0, 0, 0, 0), 0);

    queue_cfg(OP_DIVA);
    queue_pix(mk_pix(9, 8, 7, 0), mk_pix(1, 2, 3, 4), 0);
    queue_pix(mk_pix(255, 1, 0, 1), mk_pix(0, 0, 0, 0), 0);
    queue_pix(mk_pix(100, 50, 200, 200), mk_pix(0, 0, 0, 0), $urandom_range(0, 10));

    // unused codes behave as pass
    queue_cfg(OP_SPARE_HI);
    queue_pix(mk_pix(5, 6, 7, 8), mk_pix(250, 251, 252, 253), 0);
    queue_cfg(OP_SPARE_LO);
    queue_pix(mk_pix(128, 64, 32, 16), mk_pix(1, 2, 4, 8), 0);

    for (int ph = 0; ph < 20; ph++) begin
      if ($urandom_range(0, 7) == 0) code = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      else code = OP_W'($urandom_range(OP_MUL, OP_LAST_CODE));
      queue_cfg(code);
      calm = ($urandom_range(0, 3) == 0);
      n = $urandom_range(60, 140);
      for (int k = 0; k < n; k++) begin
        queue_pix(rand_pix(), rand_pix(), calm ? 0 : $urandom_range(0, 10));
        if (k == n / 2 && $urandom_range(0, 2) == 0) queue_drain();
      end
    end

    while (feed_q.size() != 0 || pin.valid || cfg_ch.valid || due_pix.size() != 0)
      @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);

    if (errors == 0 && due_pix.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
